FILE: rtl/core/aopb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopb_pkg
// Shared types and constants of the source-over pixel blend pipeline.
// ----------------------------------------------------------------------------
package aopb_pkg;

   localparam int unsigned PixW     = 8;                // one channel
   localparam int unsigned QuoW     = PixW;             // divider quotient bits
   localparam int unsigned CovW     = 2 * PixW;         // coverage * alpha
   localparam int unsigned ScaleW   = 3 * PixW;         // values scaled by 255^3
   localparam int unsigned NumW     = 4 * PixW;         // color numerators
   localparam int unsigned Chan     = 3;                // red, green, blue
   localparam int unsigned OneScale = 255;
   localparam int unsigned OneSq    = 65025;

   // opacity = floor((2A + 255^2) * OpaRecip / 2^OpaShift), exact for 2A + 255^2 < 2^25
   localparam int unsigned OpaW      = ScaleW + 2;      // 2A + 255^2
   localparam int unsigned OpaShift  = 42;
   localparam int unsigned OpaRecip  = 33818121;        // ceil(2^42 / (2 * 255^2))
   localparam int unsigned OpaRecipW = 26;

   typedef struct packed {
      logic [PixW-1:0] fg_red;
      logic [PixW-1:0] fg_green;
      logic [PixW-1:0] fg_blue;
      logic [PixW-1:0] fg_opacity;
      logic [PixW-1:0] bg_red;
      logic [PixW-1:0] bg_green;
      logic [PixW-1:0] bg_blue;
      logic [PixW-1:0] bg_opacity;
      logic [PixW-1:0] coverage;
   } req_type;

   typedef struct packed {
      logic [PixW-1:0] out_red;
      logic [PixW-1:0] out_green;
      logic [PixW-1:0] out_blue;
      logic [PixW-1:0] out_opacity;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/aopb_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopb_channels
// Valid/ready channels for the pixel request and the blended response.
// ----------------------------------------------------------------------------
interface aopb_req_if;
   logic              valid;
   logic              ready;
   aopb_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface aopb_rsp_if;
   logic              valid;
   logic              ready;
   aopb_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/alpha_over_pixel_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_over_pixel_blend
// Source-over composite of a coverage-scaled foreground pixel over a
// background pixel, un-premultiplied and rounded half up per channel.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------
//   req_if   | in        | fg RGBA, bg RGBA, coverage (9 x 8 bit)
//   rsp_if   | out       | out RGB, out opacity (4 x 8 bit)
//
// One transaction per clock while the output is not stalled; three multiply
// stages, one divider setup stage and eight divider bit stages.
// reset clears only the stage valid bits.
// All stages advance together when the output register is empty or taken;
// a stalled output freezes the whole pipeline and req_if.ready drops.
// ----------------------------------------------------------------------------
module alpha_over_pixel_blend (
   input  wire logic   clock,
   input  wire logic   reset,
   aopb_req_if.sink    req_if,
   aopb_rsp_if.source  rsp_if
);

   localparam int unsigned PixW   = aopb_pkg::PixW;
   localparam int unsigned Chan   = aopb_pkg::Chan;
   localparam int unsigned LaneLat = aopb_pkg::QuoW + 1;
   localparam int unsigned Depth  = 3 + LaneLat;
   localparam int unsigned ProdW  = aopb_pkg::OpaW + aopb_pkg::OpaRecipW;

   logic             adv;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;

   assign adv          = !vld_ff[Depth-1] || rsp_if.ready;
   assign req_if.ready = adv;
   assign vld_in       = {vld_ff[Depth-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: source alpha
   logic [aopb_pkg::CovW-1:0] cov_ff;
   logic [Chan-1:0][PixW-1:0] fg1_ff;
   logic [Chan-1:0][PixW-1:0] bg1_ff;
   logic [PixW-1:0]           ba1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cov_ff <= aopb_pkg::CovW'(req_if.data.coverage) *
                   aopb_pkg::CovW'(req_if.data.fg_opacity);
         fg1_ff <= {req_if.data.fg_blue, req_if.data.fg_green, req_if.data.fg_red};
         bg1_ff <= {req_if.data.bg_blue, req_if.data.bg_green, req_if.data.bg_red};
         ba1_ff <= req_if.data.bg_opacity;
      end
   end

   // stage 2: source and destination weights
   logic [aopb_pkg::CovW-1:0]   inv;
   logic [aopb_pkg::ScaleW-1:0] src_ff;
   logic [aopb_pkg::ScaleW-1:0] dst_ff;
   logic [Chan-1:0][PixW-1:0]   fg2_ff;
   logic [Chan-1:0][PixW-1:0]   bg2_ff;

   assign inv = aopb_pkg::CovW'(aopb_pkg::OneSq) - cov_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         src_ff <= aopb_pkg::ScaleW'(cov_ff) * aopb_pkg::ScaleW'(aopb_pkg::OneScale);
         dst_ff <= aopb_pkg::ScaleW'(ba1_ff) * aopb_pkg::ScaleW'(inv);
         fg2_ff <= fg1_ff;
         bg2_ff <= bg1_ff;
      end
   end

   // stage 3: blended alpha and weighted colors
   logic [aopb_pkg::ScaleW-1:0]         a_ff;
   logic [Chan-1:0][aopb_pkg::NumW-1:0] fn_ff;
   logic [Chan-1:0][aopb_pkg::NumW-1:0] bn_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff <= src_ff + dst_ff;
         for (int c = 0; c < Chan; c++) begin
            fn_ff[c] <= aopb_pkg::NumW'(fg2_ff[c]) * aopb_pkg::NumW'(src_ff);
            bn_ff[c] <= aopb_pkg::NumW'(bg2_ff[c]) * aopb_pkg::NumW'(dst_ff);
         end
      end
   end

   // divider lanes: colors over alpha
   logic [Chan-1:0][aopb_pkg::NumW-1:0]   lane_num;
   logic [Chan-1:0][aopb_pkg::ScaleW-1:0] lane_den;
   logic [Chan-1:0][aopb_pkg::QuoW-1:0]   lane_quo;

   always_comb begin
      for (int c = 0; c < Chan; c++) begin
         lane_num[c] = fn_ff[c] + bn_ff[c];
         lane_den[c] = a_ff;
      end
   end

   for (genvar l = 0; l < Chan; l++) begin : g_lane
      aopb_div_lane u_div (
         .clock  (clock),
         .enable (adv),
         .num    (lane_num[l]),
         .den    (lane_den[l]),
         .quo    (lane_quo[l])
      );
   end

   // opacity: alpha over 255^2 by reciprocal multiply, then hold beside the divider
   logic [aopb_pkg::OpaW-1:0]    opa_num;
   logic [ProdW-1:0]             opa_prod;
   logic [LaneLat-1:0][PixW-1:0] opa_ff;
   logic [LaneLat-1:0][PixW-1:0] opa_in;

   assign opa_num  = (aopb_pkg::OpaW'(a_ff) << 1) + aopb_pkg::OpaW'(aopb_pkg::OneSq);
   assign opa_prod = ProdW'(opa_num) * ProdW'(aopb_pkg::OpaRecip);
   assign opa_in   = {opa_ff[LaneLat-2:0], opa_prod[aopb_pkg::OpaShift +: PixW]};

   always_ff @(posedge clock) begin
      if (adv) begin
         opa_ff <= opa_in;
      end
   end

   // zero blended alpha travels beside the divider
   logic [LaneLat-1:0] zero_ff;
   logic [LaneLat-1:0] zero_in;

   assign zero_in = {zero_ff[LaneLat-2:0], (a_ff == '0)};

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff <= zero_in;
      end
   end

   logic zero;
   assign zero = zero_ff[LaneLat-1];

   assign rsp_if.valid            = vld_ff[Depth-1];
   assign rsp_if.data.out_red     = zero ? '0 : lane_quo[0];
   assign rsp_if.data.out_green   = zero ? '0 : lane_quo[1];
   assign rsp_if.data.out_blue    = zero ? '0 : lane_quo[2];
   assign rsp_if.data.out_opacity = zero ? '0 : opa_ff[LaneLat-1];

endmodule
`default_nettype wire

FILE: rtl/core/aopb_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopb_div_lane
// Pipelined restoring divider, one quotient bit per stage:
// quo = floor((2*num + den) / (2*den)), i.e. num/den rounded half up.
// ----------------------------------------------------------------------------
module aopb_div_lane (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [aopb_pkg::NumW-1:0]   num,
   input  wire logic [aopb_pkg::ScaleW-1:0] den,
   output logic      [aopb_pkg::QuoW-1:0]   quo
);

   localparam int unsigned Steps = aopb_pkg::QuoW;
   localparam int unsigned RemW  = aopb_pkg::NumW + 2;
   localparam int unsigned DivW  = aopb_pkg::ScaleW + 1;

   logic [RemW-1:0]  rem_ff [0:Steps-1];
   logic [DivW-1:0]  div_ff [0:Steps-1];
   logic [Steps-1:0] quo_ff [0:Steps];

   // form the rounding numerator and doubled divisor
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= (RemW'(num) << 1) + RemW'(den);
         div_ff[0] <= {den, 1'b0};
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < Steps; k++) begin : g_step
      localparam int unsigned Bit = Steps - 1 - k;

      logic [RemW-1:0]  shifted;
      logic             take;
      logic [Steps-1:0] quo_in;

      always_comb begin
         shifted     = RemW'(div_ff[k]) << Bit;
         take        = (rem_ff[k] >= shifted);
         quo_in      = quo_ff[k];
         quo_in[Bit] = take;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k+1] <= quo_in;
         end
      end

      if (k < Steps - 1) begin : g_carry
         logic [RemW-1:0] rem_in;

         assign rem_in = take ? (rem_ff[k] - shifted) : rem_ff[k];

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1] <= rem_in;
               div_ff[k+1] <= div_ff[k];
            end
         end
      end
   end

   assign quo = quo_ff[Steps];

endmodule
`default_nettype wire

FILE: rtl/core/aopb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aopb_checker
// Port-level checks of the blend pipeline's flow control.
// ----------------------------------------------------------------------------
module aopb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire aopb_pkg::rsp_type rsp_data
);

   // hold a stalled response
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // drop the pipeline after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // advance whenever the output is taken
   a_ready_on_take : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response is taken");

   // advance whenever the output register is empty
   a_ready_on_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // no response just out of reset without an accepted request
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response without request");

endmodule

bind alpha_over_pixel_blend aopb_checker u_aopb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
`default_nettype wire
